>>> rtl/bti_pkg.sv
// shared widths, register indexes and latency of the bilinear table interpolator
package bti_pkg;

    // transaction field widths
    localparam int ST_W      = 3;
    localparam int BAND_W    = 3;
    localparam int COORD_W   = 16;
    localparam int ZI_W      = 6;
    localparam int EI_W      = 4;
    localparam int VAL_W     = 16;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // count register widths
    localparam int ZN_W = 7;
    localparam int EN_W = 5;
    localparam int TN_W = 4;

    // quotient bits of the bin search, one bit per stage
    localparam int ZQ_W = ZN_W;
    localparam int EQ_W = EN_W;

    // datapath widths
    localparam int PROD_W = VAL_W + COORD_W + 1;
    localparam int ROW_W  = PROD_W + 1;
    localparam int PA_W   = ROW_W + 1 - 1 + 0;
    localparam int DEN_W  = 2 * COORD_W;
    localparam int DIV_W  = DEN_W + 1;
    localparam int RND_W  = DIV_W + VAL_W + 1;

    // edges from an accepted query to the edge that takes its result
    localparam int PIPE_LAT = 8 + ZQ_W + VAL_W + 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_REDSHIFT_STEP  = 3'd0,
        CFG_REDDENING_STEP = 3'd1,
        CFG_REDSHIFT_BINS  = 3'd2,
        CFG_REDDENING_BINS = 3'd3,
        CFG_TYPE_COUNT     = 3'd4
    } t_cfg_idx;

endpackage

>>> rtl/bilinear_table_interpolator.sv
// bilinear correction table: banked store, bin search pipeline and rounding divider
//
//  channel   direction  handshake                 payload
//  command   in         start high, busy low      i_req_type .. i_entry_value
//  result    out        o_valid for one cycle     o_k_value, o_reddening_clamped,
//                                                 o_type_clamped
//  config    in         i_cfg_we                  i_cfg_idx, i_cfg_data
//
// one transaction per cycle while busy is low; a query result is registered through the pipeline
// (7 bin search stages, 4 table banks read together, 16 rounding divider stages)
// writes give no result and reach the table in the same stage where queries read it
// busy is high only during reset; the table has no clearing pass after reset
// the receiver cannot stall, so the pipeline never holds
module bilinear_table_interpolator
    import bti_pkg::*;
#(
    parameter int MAX_TYPES          = 8,
    parameter int MAX_REDSHIFT_BINS  = 64,
    parameter int MAX_REDDENING_BINS = 16,
    parameter int MAX_BANDS          = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         i_req_type,
    input  logic [ST_W-1:0]              i_spectral_type,
    input  logic [BAND_W-1:0]            i_band,
    input  logic [COORD_W-1:0]           i_redshift,
    input  logic [COORD_W-1:0]           i_reddening,
    input  logic [ZI_W-1:0]              i_redshift_index,
    input  logic [EI_W-1:0]              i_reddening_index,
    input  logic signed [VAL_W-1:0]      i_entry_value,
    input  logic                         i_cfg_we,
    input  logic [CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]        i_cfg_data,
    output logic                         o_valid,
    output logic signed [VAL_W-1:0]      o_k_value,
    output logic                         o_reddening_clamped,
    output logic                         o_type_clamped
);

    localparam int TW  = (MAX_TYPES > 1) ? $clog2(MAX_TYPES) : 1;
    localparam int BW  = (MAX_BANDS > 1) ? $clog2(MAX_BANDS) : 1;
    localparam int ZW  = $clog2(MAX_REDSHIFT_BINS);
    localparam int EW  = $clog2(MAX_REDDENING_BINS);
    localparam int ZHW = (ZW > 1) ? ZW - 1 : 1;
    localparam int EHW = (EW > 1) ? EW - 1 : 1;
    localparam int BAW = TW + ZHW + EHW + BW;
    localparam int BDEPTH = 2 ** BAW;

    localparam logic [ZN_W-1:0] NZ_CAP = ZN_W'((MAX_REDSHIFT_BINS < 2 ** ZN_W - 1) ?
                                               MAX_REDSHIFT_BINS : 2 ** ZN_W - 1);
    localparam logic [EN_W-1:0] NE_CAP = EN_W'((MAX_REDDENING_BINS < 2 ** EN_W - 1) ?
                                               MAX_REDDENING_BINS : 2 ** EN_W - 1);
    localparam logic [TN_W-1:0] NT_CAP = TN_W'((MAX_TYPES < 2 ** TN_W - 1) ?
                                               MAX_TYPES : 2 ** TN_W - 1);

    typedef struct packed {
        logic                vld;
        logic                query;
        logic [ST_W-1:0]     st;
        logic [BAND_W-1:0]   band;
        logic [COORD_W-1:0]  zq;
        logic [COORD_W-1:0]  eq;
        logic [ZI_W-1:0]     zi;
        logic [EI_W-1:0]     ei;
        logic [VAL_W-1:0]    data;
    } t_in;

    typedef struct packed {
        logic                   vld;
        logic                   wr;
        logic                   wen;
        logic [1:0]             wbank;
        logic [BAW-1:0]         waddr;
        logic [VAL_W-1:0]       wdata;
        logic [TW-1:0]          t;
        logic [BW-1:0]          b;
        logic                   tflag;
        logic [COORD_W-1:0]     zs;
        logic [COORD_W-1:0]     es;
        logic [COORD_W-1:0]     zrem;
        logic [COORD_W-1:0]     erem;
        logic [ZN_W-1:0]        nz;
        logic [EN_W-1:0]        ne;
        logic [ZN_W+COORD_W-1:0] zlim;
        logic [EN_W+COORD_W-1:0] elim;
        logic                   zclamp;
        logic                   eclamp;
        logic                   elin;
        logic [ZQ_W-1:0]        zqt;
        logic [EQ_W-1:0]        eqt;
    } t_dv;

    typedef struct packed {
        logic                   vld;
        logic                   wr;
        logic                   wen;
        logic [1:0]             wbank;
        logic [BAW-1:0]         waddr;
        logic [VAL_W-1:0]       wdata;
        logic [3:0][BAW-1:0]    raddr;
        logic [1:0]             c11;
        logic [1:0]             c21;
        logic [1:0]             c12;
        logic [1:0]             c22;
        logic [COORD_W-1:0]     wz0;
        logic [COORD_W-1:0]     wz1;
        logic [COORD_W-1:0]     we0;
        logic [COORD_W-1:0]     we1;
        logic [COORD_W-1:0]     zden;
        logic [COORD_W-1:0]     eden;
        logic                   eflag;
        logic                   tflag;
    } t_adr;

    typedef struct packed {
        logic               vld;
        logic [1:0]         c11;
        logic [1:0]         c21;
        logic [1:0]         c12;
        logic [1:0]         c22;
        logic [COORD_W-1:0] wz0;
        logic [COORD_W-1:0] wz1;
        logic [COORD_W-1:0] we0;
        logic [COORD_W-1:0] we1;
        logic [COORD_W-1:0] zden;
        logic [COORD_W-1:0] eden;
        logic               eflag;
        logic               tflag;
    } t_rd;

    typedef struct packed {
        logic                      vld;
        logic signed [PROD_W-1:0]  p11;
        logic signed [PROD_W-1:0]  p21;
        logic signed [PROD_W-1:0]  p12;
        logic signed [PROD_W-1:0]  p22;
        logic [COORD_W-1:0]        we0;
        logic [COORD_W-1:0]        we1;
        logic [COORD_W-1:0]        zden;
        logic [COORD_W-1:0]        eden;
        logic                      eflag;
        logic                      tflag;
    } t_m1;

    typedef struct packed {
        logic                     vld;
        logic signed [ROW_W-1:0]  r1;
        logic signed [ROW_W-1:0]  r2;
        logic [COORD_W-1:0]       we0;
        logic [COORD_W-1:0]       we1;
        logic [DEN_W-1:0]         dd;
        logic                     eflag;
        logic                     tflag;
    } t_m2;

    typedef struct packed {
        logic                      vld;
        logic [ROW_W-1:0]          pa;
        logic signed [ROW_W:0]     pb;
        logic [DEN_W-1:0]          dd;
        logic                      eflag;
        logic                      tflag;
    } t_m3;

    typedef struct packed {
        logic               vld;
        logic [RND_W-1:0]   rem;
        logic [DIV_W-1:0]   dv;
        logic [VAL_W-1:0]   q;
        logic               eflag;
        logic               tflag;
    } t_nd;

    // configuration registers
    logic [COORD_W-1:0] r_redshift_step;
    logic [COORD_W-1:0] r_reddening_step;
    logic [ZN_W-1:0]    r_redshift_bins;
    logic [EN_W-1:0]    r_reddening_bins;
    logic [TN_W-1:0]    r_type_count;
    logic               r_busy;

    t_in  r_in, n_in;
    t_dv  r_s2, n_s2;
    t_dv  r_dv [ZQ_W+1];
    t_dv  n_dv [ZQ_W+1];
    t_adr r_adr, n_adr;
    t_rd  r_rd, n_rd;
    t_m1  r_m1, n_m1;
    t_m2  r_m2, n_m2;
    t_m3  r_m3, n_m3;
    t_nd  r_nd [VAL_W+1];
    t_nd  n_nd [VAL_W+1];

    logic [VAL_W-1:0] rd_data [4];

    logic [ZN_W-1:0] eff_nz;
    logic [EN_W-1:0] eff_ne;
    logic [TN_W-1:0] eff_nt;
    logic            tfl;
    logic [TN_W-1:0] t_eff;

    logic [ZN_W-1:0]    iz, izp;
    logic [EN_W-1:0]    ie, iep;
    logic               lastz, laste;
    logic [COORD_W-1:0] rz, re, zden, eden;
    logic [ZN_W-1:0]    zsel [4];
    logic [EN_W-1:0]    esel [4];

    logic signed [VAL_W-1:0] q11, q21, q12, q22;
    logic [16:0]             r1l, r2l;
    logic signed [16:0]      r1h, r2h;
    logic [PROD_W-1:0]       pa1, pa2;
    logic signed [ROW_W-1:0] pb1, pb2;
    logic [ROW_W+17:0]       numv;
    logic [ROW_W+19:0]       nn;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_redshift_step  <= COORD_W'(410);
            r_reddening_step <= COORD_W'(205);
            r_redshift_bins  <= ZN_W'(64);
            r_reddening_bins <= EN_W'(16);
            r_type_count     <= TN_W'(8);
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_REDSHIFT_STEP:  r_redshift_step  <= i_cfg_data;
                CFG_REDDENING_STEP: r_reddening_step <= i_cfg_data;
                CFG_REDSHIFT_BINS:  r_redshift_bins  <= i_cfg_data[ZN_W-1:0];
                CFG_REDDENING_BINS: r_reddening_bins <= i_cfg_data[EN_W-1:0];
                CFG_TYPE_COUNT:     r_type_count     <= i_cfg_data[TN_W-1:0];
                default: ;
            endcase
        end
    end

    // busy only while in reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
    end
    assign busy = r_busy;

    // input register
    always_comb begin
        n_in.vld   = start & ~r_busy;
        n_in.query = i_req_type;
        n_in.st    = i_spectral_type;
        n_in.band  = i_band;
        n_in.zq    = i_redshift;
        n_in.eq    = i_reddening;
        n_in.zi    = i_redshift_index;
        n_in.ei    = i_reddening_index;
        n_in.data  = i_entry_value;
    end

    always_ff @(posedge i_clk) begin
        r_in <= n_in;
        if (!i_rst_n) begin
            r_in.vld <= 1'b0;
        end
    end

    // effective counts, index clamps, write address and bin limits
    assign eff_nz = (r_redshift_bins == '0) ? ZN_W'(1) :
                    (r_redshift_bins > NZ_CAP) ? NZ_CAP : r_redshift_bins;
    assign eff_ne = (r_reddening_bins == '0) ? EN_W'(1) :
                    (r_reddening_bins > NE_CAP) ? NE_CAP : r_reddening_bins;
    assign eff_nt = (r_type_count == '0) ? TN_W'(1) :
                    (r_type_count > NT_CAP) ? NT_CAP : r_type_count;
    assign tfl    = {1'b0, r_in.st} >= eff_nt;
    assign t_eff  = tfl ? eff_nt - TN_W'(1) : {1'b0, r_in.st};

    always_comb begin
        n_s2       = '0;
        n_s2.vld   = r_in.vld;
        n_s2.wr    = ~r_in.query;
        n_s2.wen   = (32'(r_in.st) < MAX_TYPES) && (32'(r_in.band) < MAX_BANDS) &&
                     (32'(r_in.zi) < MAX_REDSHIFT_BINS) && (32'(r_in.ei) < MAX_REDDENING_BINS);
        n_s2.wbank = {r_in.ei[0], r_in.zi[0]};
        n_s2.waddr = {TW'(r_in.st), ZHW'(r_in.zi >> 1), EHW'(r_in.ei >> 1), BW'(r_in.band)};
        n_s2.wdata = r_in.data;
        n_s2.t     = TW'(t_eff);
        n_s2.b     = (32'(r_in.band) < MAX_BANDS) ? BW'(r_in.band) : BW'(MAX_BANDS - 1);
        n_s2.tflag = tfl;
        n_s2.zs    = r_redshift_step;
        n_s2.es    = r_reddening_step;
        n_s2.zrem  = r_in.zq;
        n_s2.erem  = r_in.eq;
        n_s2.nz    = eff_nz;
        n_s2.ne    = eff_ne;
        n_s2.zlim  = eff_nz * r_redshift_step;
        n_s2.elim  = eff_ne * r_reddening_step;
    end

    always_ff @(posedge i_clk) begin
        r_s2 <= n_s2;
        if (!i_rst_n) begin
            r_s2.vld <= 1'b0;
        end
    end

    // past-the-end checks; a zero step lands in the last bin, save a zero reddening (linear mode)
    always_comb begin
        n_dv[0]        = r_s2;
        n_dv[0].zclamp = {ZN_W'(0), r_s2.zrem} >= r_s2.zlim;
        n_dv[0].eclamp = {EN_W'(0), r_s2.erem} >= r_s2.elim;
        n_dv[0].elin   = (r_s2.erem == '0);
        n_dv[0].zqt    = '0;
        n_dv[0].eqt    = '0;
    end

    always_ff @(posedge i_clk) begin
        r_dv[0] <= n_dv[0];
        if (!i_rst_n) begin
            r_dv[0].vld <= 1'b0;
        end
    end

    // bin search: one redshift quotient bit per stage, one reddening bit in each of the first EQ_W
    for (genvar k = 0; k < ZQ_W; k++) begin : g_bin
        localparam int ZB = ZQ_W - 1 - k;
        localparam int EB = EQ_W - 1 - k;
        logic [COORD_W+ZQ_W-1:0] cz;
        logic [COORD_W+EQ_W-1:0] ce;

        always_comb begin
            n_dv[k+1] = r_dv[k];
            cz = {ZQ_W'(0), r_dv[k].zs} << ZB;
            ce = '0;
            if ({ZQ_W'(0), r_dv[k].zrem} >= cz) begin
                n_dv[k+1].zrem    = r_dv[k].zrem - cz[COORD_W-1:0];
                n_dv[k+1].zqt[ZB] = 1'b1;
            end
            if (k < EQ_W) begin
                ce = {EQ_W'(0), r_dv[k].es} << EB;
                if ({EQ_W'(0), r_dv[k].erem} >= ce) begin
                    n_dv[k+1].erem                 = r_dv[k].erem - ce[COORD_W-1:0];
                    n_dv[k+1].eqt[EB % EQ_W]       = 1'b1;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            r_dv[k+1] <= n_dv[k+1];
            if (!i_rst_n) begin
                r_dv[k+1].vld <= 1'b0;
            end
        end
    end

    // bins, neighbours, weights and bank addresses
    always_comb begin
        iz    = r_dv[ZQ_W].zclamp ? r_dv[ZQ_W].nz - ZN_W'(1) : r_dv[ZQ_W].zqt;
        lastz = (iz == r_dv[ZQ_W].nz - ZN_W'(1));
        izp   = lastz ? iz : iz + ZN_W'(1);
        rz    = lastz ? '0 : r_dv[ZQ_W].zrem;
        zden  = (r_dv[ZQ_W].zs == '0) ? COORD_W'(1) : r_dv[ZQ_W].zs;

        if (r_dv[ZQ_W].elin) begin
            ie    = '0;
            laste = 1'b1;
            iep   = '0;
            re    = '0;
            eden  = COORD_W'(1);
        end else begin
            ie    = r_dv[ZQ_W].eclamp ? r_dv[ZQ_W].ne - EN_W'(1) : r_dv[ZQ_W].eqt;
            laste = (ie == r_dv[ZQ_W].ne - EN_W'(1));
            iep   = laste ? ie : ie + EN_W'(1);
            re    = laste ? '0 : r_dv[ZQ_W].erem;
            eden  = (r_dv[ZQ_W].es == '0) ? COORD_W'(1) : r_dv[ZQ_W].es;
        end

        n_adr.vld   = r_dv[ZQ_W].vld;
        n_adr.wr    = r_dv[ZQ_W].wr;
        n_adr.wen   = r_dv[ZQ_W].wen;
        n_adr.wbank = r_dv[ZQ_W].wbank;
        n_adr.waddr = r_dv[ZQ_W].waddr;
        n_adr.wdata = r_dv[ZQ_W].wdata;
        for (int g = 0; g < 4; g++) begin
            zsel[g] = (iz[0] == g[0]) ? iz : izp;
            esel[g] = (ie[0] == g[1]) ? ie : iep;
            n_adr.raddr[g] = {r_dv[ZQ_W].t, ZHW'(zsel[g] >> 1), EHW'(esel[g] >> 1),
                              r_dv[ZQ_W].b};
        end
        n_adr.c11   = {ie[0], iz[0]};
        n_adr.c21   = {ie[0], izp[0]};
        n_adr.c12   = {iep[0], iz[0]};
        n_adr.c22   = {iep[0], izp[0]};
        n_adr.wz0   = zden - rz;
        n_adr.wz1   = rz;
        n_adr.we0   = eden - re;
        n_adr.we1   = re;
        n_adr.zden  = zden;
        n_adr.eden  = eden;
        n_adr.eflag = ~r_dv[ZQ_W].elin & r_dv[ZQ_W].eclamp;
        n_adr.tflag = r_dv[ZQ_W].tflag;
    end

    always_ff @(posedge i_clk) begin
        r_adr <= n_adr;
        if (!i_rst_n) begin
            r_adr.vld <= 1'b0;
        end
    end

    // four table banks split by redshift and reddening bin parity
    for (genvar g = 0; g < 4; g++) begin : g_bank
        logic [VAL_W-1:0] mem [BDEPTH];
        logic [VAL_W-1:0] r_q;

        always_ff @(posedge i_clk) begin
            if (r_adr.vld && r_adr.wr && r_adr.wen && (r_adr.wbank == 2'(g))) begin
                mem[r_adr.waddr] <= r_adr.wdata;
            end
            r_q <= mem[r_adr.raddr[g]];
        end

        assign rd_data[g] = r_q;
    end

    always_comb begin
        n_rd.vld   = r_adr.vld & ~r_adr.wr;
        n_rd.c11   = r_adr.c11;
        n_rd.c21   = r_adr.c21;
        n_rd.c12   = r_adr.c12;
        n_rd.c22   = r_adr.c22;
        n_rd.wz0   = r_adr.wz0;
        n_rd.wz1   = r_adr.wz1;
        n_rd.we0   = r_adr.we0;
        n_rd.we1   = r_adr.we1;
        n_rd.zden  = r_adr.zden;
        n_rd.eden  = r_adr.eden;
        n_rd.eflag = r_adr.eflag;
        n_rd.tflag = r_adr.tflag;
    end

    always_ff @(posedge i_clk) begin
        r_rd <= n_rd;
        if (!i_rst_n) begin
            r_rd.vld <= 1'b0;
        end
    end

    // corner times redshift weight
    always_comb begin
        q11 = $signed(rd_data[r_rd.c11]);
        q21 = $signed(rd_data[r_rd.c21]);
        q12 = $signed(rd_data[r_rd.c12]);
        q22 = $signed(rd_data[r_rd.c22]);
        n_m1.vld   = r_rd.vld;
        n_m1.p11   = q11 * $signed({1'b0, r_rd.wz0});
        n_m1.p21   = q21 * $signed({1'b0, r_rd.wz1});
        n_m1.p12   = q12 * $signed({1'b0, r_rd.wz0});
        n_m1.p22   = q22 * $signed({1'b0, r_rd.wz1});
        n_m1.we0   = r_rd.we0;
        n_m1.we1   = r_rd.we1;
        n_m1.zden  = r_rd.zden;
        n_m1.eden  = r_rd.eden;
        n_m1.eflag = r_rd.eflag;
        n_m1.tflag = r_rd.tflag;
    end

    always_ff @(posedge i_clk) begin
        r_m1 <= n_m1;
        if (!i_rst_n) begin
            r_m1.vld <= 1'b0;
        end
    end

    // row sums and the full denominator
    always_comb begin
        n_m2.vld   = r_m1.vld;
        n_m2.r1    = {r_m1.p11[PROD_W-1], r_m1.p11} + {r_m1.p21[PROD_W-1], r_m1.p21};
        n_m2.r2    = {r_m1.p12[PROD_W-1], r_m1.p12} + {r_m1.p22[PROD_W-1], r_m1.p22};
        n_m2.we0   = r_m1.we0;
        n_m2.we1   = r_m1.we1;
        n_m2.dd    = r_m1.zden * r_m1.eden;
        n_m2.eflag = r_m1.eflag;
        n_m2.tflag = r_m1.tflag;
    end

    always_ff @(posedge i_clk) begin
        r_m2 <= n_m2;
        if (!i_rst_n) begin
            r_m2.vld <= 1'b0;
        end
    end

    // reddening weights, row sums split into low and high halves
    always_comb begin
        r1l = r_m2.r1[16:0];
        r2l = r_m2.r2[16:0];
        r1h = r_m2.r1[ROW_W-1:17];
        r2h = r_m2.r2[ROW_W-1:17];
        pa1 = r1l * r_m2.we0;
        pa2 = r2l * r_m2.we1;
        pb1 = r1h * $signed({1'b0, r_m2.we0});
        pb2 = r2h * $signed({1'b0, r_m2.we1});
        n_m3.vld   = r_m2.vld;
        n_m3.pa    = {1'b0, pa1} + {1'b0, pa2};
        n_m3.pb    = {pb1[ROW_W-1], pb1} + {pb2[ROW_W-1], pb2};
        n_m3.dd    = r_m2.dd;
        n_m3.eflag = r_m2.eflag;
        n_m3.tflag = r_m2.tflag;
    end

    always_ff @(posedge i_clk) begin
        r_m3 <= n_m3;
        if (!i_rst_n) begin
            r_m3.vld <= 1'b0;
        end
    end

    // rounding numerator, offset by half the output range so the quotient is unsigned
    always_comb begin
        numv = {r_m3.pb, 17'd0} + {18'd0, r_m3.pa};
        nn   = {numv[ROW_W+17], numv, 1'b0} + {22'd0, r_m3.dd} + {6'd0, r_m3.dd, 16'd0};
        n_nd[0].vld   = r_m3.vld;
        n_nd[0].rem   = nn[RND_W-1:0];
        n_nd[0].dv    = {r_m3.dd, 1'b0};
        n_nd[0].q     = '0;
        n_nd[0].eflag = r_m3.eflag;
        n_nd[0].tflag = r_m3.tflag;
    end

    always_ff @(posedge i_clk) begin
        r_nd[0] <= n_nd[0];
        if (!i_rst_n) begin
            r_nd[0].vld <= 1'b0;
        end
    end

    // restoring divider, one quotient bit per stage
    for (genvar k = 0; k < VAL_W; k++) begin : g_div
        localparam int QB = VAL_W - 1 - k;
        logic [RND_W-1:0] cand;

        always_comb begin
            n_nd[k+1] = r_nd[k];
            cand = {(RND_W - DIV_W)'(0), r_nd[k].dv} << QB;
            if (r_nd[k].rem >= cand) begin
                n_nd[k+1].rem   = r_nd[k].rem - cand;
                n_nd[k+1].q[QB] = 1'b1;
            end
        end

        always_ff @(posedge i_clk) begin
            r_nd[k+1] <= n_nd[k+1];
            if (!i_rst_n) begin
                r_nd[k+1].vld <= 1'b0;
            end
        end
    end

    // result: remove the offset from the quotient
    assign o_valid             = r_nd[VAL_W].vld;
    assign o_k_value           = $signed({~r_nd[VAL_W].q[VAL_W-1], r_nd[VAL_W].q[VAL_W-2:0]});
    assign o_reddening_clamped = r_nd[VAL_W].eflag;
    assign o_type_clamped      = r_nd[VAL_W].tflag;

endmodule

>>> rtl/bti_checker.sv
// port-level checks of the bilinear table interpolator, bound to the top level
module bti_checker
    import bti_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                start,
    input logic                busy,
    input logic                i_req_type,
    input logic [ST_W-1:0]     i_spectral_type,
    input logic [COORD_W-1:0]  i_reddening,
    input logic                o_valid,
    input logic                o_reddening_clamped,
    input logic                o_type_clamped
);

    // busy follows reset
    a_busy_in_reset: assert property (@(posedge i_clk) !i_rst_n |=> busy)
        else $error("busy low after a reset cycle");

    // a result only for a query accepted a fixed latency earlier
    a_result_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy && i_req_type, PIPE_LAT))
        else $error("result without a matching query transaction");

    // type clamp needs a nonzero type
    a_type_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_type_clamped) |-> ($past(i_spectral_type, PIPE_LAT) != '0))
        else $error("type clamp on type zero");

    // reddening clamp never in linear mode
    a_redd_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_reddening_clamped) |-> ($past(i_reddening, PIPE_LAT) != '0))
        else $error("reddening clamp on zero reddening");

endmodule

bind bilinear_table_interpolator bti_checker u_bti_checker (.*);

>>> sim/bilinear_table_interpolator_test.sv
// self-checking testbench for the bilinear correction table interpolator
`timescale 1ns / 100ps

module bilinear_table_interpolator_test;
    import bti_pkg::*;

    localparam int N_TYPES  = 8;
    localparam int N_ZBINS  = 64;
    localparam int N_EBINS  = 16;
    localparam int N_BANDS  = 8;
    localparam int DEPTH    = N_TYPES * N_ZBINS * N_EBINS * N_BANDS;
    localparam int N_PHASES = 8;
    localparam int QUERIES_PER_PHASE = 70;

    typedef struct {
        logic                    is_query;
        logic [ST_W-1:0]         stype;
        logic [BAND_W-1:0]       band;
        logic [COORD_W-1:0]      z;
        logic [COORD_W-1:0]      e;
        logic [ZI_W-1:0]         zi;
        logic [EI_W-1:0]         ei;
        logic signed [VAL_W-1:0] value;
    } t_cmd;

    typedef struct {
        logic signed [VAL_W-1:0] k;
        logic                    e_clamp;
        logic                    t_clamp;
    } t_kcorr;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    start;
    logic                    busy;
    logic                    i_req_type;
    logic [ST_W-1:0]         i_spectral_type;
    logic [BAND_W-1:0]       i_band;
    logic [COORD_W-1:0]      i_redshift;
    logic [COORD_W-1:0]      i_reddening;
    logic [ZI_W-1:0]         i_redshift_index;
    logic [EI_W-1:0]         i_reddening_index;
    logic signed [VAL_W-1:0] i_entry_value;
    logic                    i_cfg_we;
    logic [CFG_IDX_W-1:0]    i_cfg_idx;
    logic [CFG_DATA_W-1:0]   i_cfg_data;
    logic                    o_valid;
    logic signed [VAL_W-1:0] o_k_value;
    logic                    o_reddening_clamped;
    logic                    o_type_clamped;

    // shadow copy of table and registers
    logic signed [VAL_W-1:0] shadow_table [DEPTH];
    bit                      planned [DEPTH];
    int unsigned             z_step, e_step, z_bins, e_bins, t_count;

    t_cmd   cmd_queue [$];
    t_kcorr kcorr_queue [$];
    t_cmd   cur_cmd;
    bit     quiet;
    int     errors, n_queries, n_writes, n_eclamp, n_tclamp;

    bilinear_table_interpolator i_dut (.*);

    // clock
    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    function automatic int unsigned clamp_count(int unsigned r, int unsigned m);
        if (r == 0) return 1;
        return (r > m) ? m : r;
    endfunction

    function automatic int table_addr(int unsigned t, int unsigned z, int unsigned e,
                                      int unsigned b);
        return ((t * N_ZBINS + z) * N_EBINS + e) * N_BANDS + b;
    endfunction

    // floor((2n + d) / 2d), ties toward plus infinity
    function automatic longint round_nearest(longint n, longint d);
        longint num, den, q;
        num = 2 * n + d;
        den = 2 * d;
        q = num / den;
        if ((num % den) != 0 && num < 0) q--;
        return q;
    endfunction

    // interpolated correction and the four corner addresses it reads
    function automatic void interpolate(input t_cmd c, output t_kcorr r, output int corner [4]);
        int unsigned nz, ne, nt, t, iz, izp, rz, ie, iep, re;
        longint zden, eden, q11, q21, q12, q22, r1, r2, v;
        nz = clamp_count(z_bins, N_ZBINS);
        ne = clamp_count(e_bins, N_EBINS);
        nt = clamp_count(t_count, N_TYPES);
        t = c.stype;
        r.t_clamp = 1'b0;
        r.e_clamp = 1'b0;
        if (t >= nt) begin
            t = nt - 1;
            r.t_clamp = 1'b1;
        end
        if (z_step == 0) begin
            iz = nz - 1;
            rz = 0;
        end else begin
            iz = c.z / z_step;
            if (iz >= nz) iz = nz - 1;
            rz = c.z - iz * z_step;
        end
        izp = iz + 1;
        if (iz == nz - 1) begin
            izp = iz;
            rz = 0;
        end
        zden = (z_step != 0) ? z_step : 1;
        if (c.e == 0) begin
            corner[0] = table_addr(t, iz, 0, c.band);
            corner[1] = table_addr(t, izp, 0, c.band);
            corner[2] = corner[0];
            corner[3] = corner[1];
            q11 = shadow_table[corner[0]];
            q21 = shadow_table[corner[1]];
            v = round_nearest(q11 * zden + (q21 - q11) * longint'(rz), zden);
        end else begin
            if (e_step == 0) begin
                ie = ne;
                re = 0;
            end else begin
                ie = c.e / e_step;
                re = (ie < ne) ? c.e - ie * e_step : 0;
            end
            if (ie >= ne) begin
                ie = ne - 1;
                r.e_clamp = 1'b1;
                re = 0;
            end
            iep = ie + 1;
            if (ie == ne - 1) begin
                iep = ie;
                re = 0;
            end
            eden = (e_step != 0) ? e_step : 1;
            corner[0] = table_addr(t, iz, ie, c.band);
            corner[1] = table_addr(t, izp, ie, c.band);
            corner[2] = table_addr(t, iz, iep, c.band);
            corner[3] = table_addr(t, izp, iep, c.band);
            q11 = shadow_table[corner[0]];
            q21 = shadow_table[corner[1]];
            q12 = shadow_table[corner[2]];
            q22 = shadow_table[corner[3]];
            r1 = q11 * (zden - longint'(rz)) + q21 * longint'(rz);
            r2 = q12 * (zden - longint'(rz)) + q22 * longint'(rz);
            v = round_nearest(r1 * (eden - longint'(re)) + r2 * longint'(re), zden * eden);
        end
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        r.k = VAL_W'(v);
    endfunction

    function automatic logic signed [VAL_W-1:0] pick_value();
        case ($urandom_range(7))
            0:       return 16'sh8000;
            1:       return 16'sh7fff;
            default: return VAL_W'($urandom);
        endcase
    endfunction

    function automatic t_cmd random_write();
        t_cmd c;
        c.is_query = 1'b0;
        c.stype = ST_W'($urandom);
        c.band  = BAND_W'($urandom);
        c.z     = COORD_W'($urandom);
        c.e     = COORD_W'($urandom);
        c.zi    = ZI_W'($urandom);
        c.ei    = EI_W'($urandom);
        c.value = pick_value();
        return c;
    endfunction

    // queue a query, preceded by writes of any corner not yet loaded
    task automatic queue_query(input t_cmd q);
        t_kcorr dummy;
        int     corner [4];
        t_cmd   w;
        q.is_query = 1'b1;
        interpolate(q, dummy, corner);
        foreach (corner[i]) begin
            if (!planned[corner[i]]) begin
                w = random_write();
                w.band  = corner[i] % N_BANDS;
                w.ei    = (corner[i] / N_BANDS) % N_EBINS;
                w.zi    = (corner[i] / (N_BANDS * N_EBINS)) % N_ZBINS;
                w.stype = corner[i] / (N_BANDS * N_EBINS * N_ZBINS);
                planned[corner[i]] = 1'b1;
                cmd_queue.push_back(w);
            end
        end
        cmd_queue.push_back(q);
    endtask

    task automatic random_query();
        t_cmd        q;
        int unsigned span;
        q = random_write();
        span = clamp_count(z_bins, N_ZBINS) * ((z_step != 0) ? z_step : 1);
        if ($urandom_range(1) && span > 0)
            q.z = COORD_W'($urandom_range((span > 65535) ? 65535 : span - 1));
        span = clamp_count(e_bins, N_EBINS) * ((e_step != 0) ? e_step : 1);
        case ($urandom_range(3))
            0: q.e = '0;
            1: q.e = COORD_W'($urandom_range((span > 65535) ? 65535 : span));
            default: q.e = COORD_W'($urandom);
        endcase
        queue_query(q);
    endtask

    task automatic wait_drained();
        while (cmd_queue.size() != 0 || start || kcorr_queue.size() != 0)
            @(posedge i_clk);
    endtask

    // register writes, only while nothing is in flight
    task automatic write_regs(input int unsigned zs, es, zn, en, tn);
        int unsigned vals [5];
        vals = '{zs, es, zn, en, tn};
        repeat (PIPE_LAT + 8) @(posedge i_clk);
        for (int i = 0; i < 5; i++) begin
            @(posedge i_clk);
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= CFG_IDX_W'(i);
            i_cfg_data <= CFG_DATA_W'(vals[i]);
        end
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        z_step  = zs & 16'hffff;
        e_step  = es & 16'hffff;
        z_bins  = zn & 7'h7f;
        e_bins  = en & 5'h1f;
        t_count = tn & 4'hf;
    endtask

    // command driver
    always @(posedge i_clk) begin
        t_kcorr r;
        int     corner [4];
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                if (cur_cmd.is_query) begin
                    interpolate(cur_cmd, r, corner);
                    kcorr_queue.push_back(r);
                    n_queries++;
                end else begin
                    shadow_table[table_addr(cur_cmd.stype, cur_cmd.zi, cur_cmd.ei,
                                            cur_cmd.band)] = cur_cmd.value;
                    n_writes++;
                end
            end
            if (!start || !busy) begin
                if (cmd_queue.size() != 0 && (quiet || $urandom_range(99) >= 22)) begin
                    cur_cmd = cmd_queue.pop_front();
                    start             <= 1'b1;
                    i_req_type        <= cur_cmd.is_query;
                    i_spectral_type   <= cur_cmd.stype;
                    i_band            <= cur_cmd.band;
                    i_redshift        <= cur_cmd.z;
                    i_reddening       <= cur_cmd.e;
                    i_redshift_index  <= cur_cmd.zi;
                    i_reddening_index <= cur_cmd.ei;
                    i_entry_value     <= cur_cmd.value;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        t_kcorr x;
        if (i_rst_n && o_valid) begin
            if (kcorr_queue.size() == 0) begin
                $error("unexpected result k_value %0d", o_k_value);
                errors++;
            end else begin
                x = kcorr_queue.pop_front();
                if (o_k_value !== x.k) begin
                    $error("k_value expected %0d actual %0d", x.k, o_k_value);
                    errors++;
                end
                if (o_reddening_clamped !== x.e_clamp) begin
                    $error("reddening_clamped expected %0b actual %0b", x.e_clamp,
                           o_reddening_clamped);
                    errors++;
                end
                if (o_type_clamped !== x.t_clamp) begin
                    $error("type_clamped expected %0b actual %0b", x.t_clamp, o_type_clamped);
                    errors++;
                end
                n_eclamp += x.e_clamp;
                n_tclamp += x.t_clamp;
            end
        end
    end

    // watchdog
    initial begin
        #(12ns * 1500000);
        $display("DONE: errors detected");
        $finish;
    end

    // stimulus
    initial begin
        int unsigned cfg [N_PHASES][5];
        t_cmd        q;
        cfg = '{'{410, 205, 64, 16, 8}, '{1, 1, 64, 16, 8}, '{65535, 65535, 2, 2, 1},
                '{0, 0, 5, 3, 4}, '{1000, 3000, 0, 0, 0}, '{2048, 4096, 127, 31, 15},
                '{300, 700, 1, 1, 3}, '{65535, 1, 64, 16, 8}};
        start = 1'b0;
        i_req_type = 1'b0;
        i_spectral_type = '0;
        i_band = '0;
        i_redshift = '0;
        i_reddening = '0;
        i_redshift_index = '0;
        i_reddening_index = '0;
        i_entry_value = '0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_REDSHIFT_STEP;
        i_cfg_data = '0;
        errors = 0;
        n_queries = 0;
        n_writes = 0;
        n_eclamp = 0;
        n_tclamp = 0;
        quiet = 1'b0;
        z_step = 410;
        e_step = 205;
        z_bins = 64;
        e_bins = 16;
        t_count = 8;
        i_rst_n = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int p = 0; p < N_PHASES; p++) begin
            write_regs(cfg[p][0], cfg[p][1], cfg[p][2], cfg[p][3], cfg[p][4]);
            quiet = (p == 1);
            if (p == 0) begin
                // directed: coordinate extremes, linear and bilinear mode, edge types and bands
                for (int i = 0; i < 12; i++) begin
                    q = random_write();
                    q.z     = (i % 3 == 0) ? 16'h0000 : (i % 3 == 1) ? 16'hffff : 16'd615;
                    q.e     = (i % 4 == 0) ? 16'h0000 : (i % 4 == 1) ? 16'h0001 :
                              (i % 4 == 2) ? 16'hffff : 16'd300;
                    q.stype = (i < 6) ? 3'd0 : 3'd7;
                    q.band  = (i % 2) ? 3'd7 : 3'd0;
                    queue_query(q);
                end
            end
            for (int half = 0; half < 2; half++) begin
                for (int i = 0; i < QUERIES_PER_PHASE / 2; i++) begin
                    if ($urandom_range(9) == 0) begin
                        q = random_write();
                        planned[table_addr(q.stype, q.zi, q.ei, q.band)] = 1'b1;
                        cmd_queue.push_back(q);
                    end
                    random_query();
                end
                // sender holds off until every result is back
                wait_drained();
            end
        end

        repeat (PIPE_LAT + 8) @(posedge i_clk);
        $display("covered %0d queries and %0d table writes over %0d register settings",
                 n_queries, n_writes, N_PHASES);
        $display("reddening clamps %0d, type clamps %0d", n_eclamp, n_tclamp);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
